// ----- rtl/coo_to_csc_permuted_assert.svh -----
// Assertion macros shared by the converter RTL.
`ifndef COO_TO_CSC_PERMUTED_ASSERT_SVH
`define COO_TO_CSC_PERMUTED_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("coo_to_csc_permuted: check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define CTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coo_to_csc_permuted: check failed");

`endif

// ----- rtl/ctc_pkg.sv -----
// Types and codes of the permuted coordinate-to-compressed-column converter.
package ctc_pkg;

	localparam logic [3:0] F_PERM    = 4'd0;
	localparam logic [3:0] F_ADD_L   = 4'd1;
	localparam logic [3:0] F_ADD_U   = 4'd2;
	localparam logic [3:0] F_BUILD   = 4'd3;
	localparam logic [3:0] F_RD_LPTR = 4'd4;
	localparam logic [3:0] F_RD_LENT = 4'd5;
	localparam logic [3:0] F_RD_UPTR = 4'd6;
	localparam logic [3:0] F_RD_UENT = 4'd7;
	localparam logic [3:0] F_CLEAR   = 4'd8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic [63:0] val;
	} coo_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic [63:0] val;
	} csc_t;

endpackage

// ----- rtl/ctc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/coo_to_csc_permuted.sv -----
// Top level: permuted coordinate-to-compressed-column converter.
//
//  channel   signals                                        direction
//  config    dim_we, dim_wdata                               in
//  request   start/busy, func, pos, perm_*_entry, row, col,  in
//            value
//  result    done, status, ptr_out, index_out, value_out,    out
//            l_nnz, u_nnz
//
// Loads, reads and clear take one request per cycle while busy is low; the result
// strobes after acceptance through the memory read, then the output register.
// Build holds busy while, per form, it runs a fill-memory clearing sweep, a count
// pass, a prefix pass and a scatter pass.
// Reset clears control state only; stores are not swept. No stall on results.
`include "coo_to_csc_permuted_assert.svh"

module coo_to_csc_permuted #(
	parameter int MAX_DIM = 256,
	parameter int MAX_NNZ = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             dim_we,
	input  logic [8:0]       dim_wdata,
	input  logic             start,
	output logic             busy,
	input  logic [3:0]       func,
	input  logic [12:0]      pos,
	input  logic [7:0]       perm_row_entry,
	input  logic [7:0]       perm_col_entry,
	input  logic [7:0]       row,
	input  logic [7:0]       col,
	input  logic [63:0]      value,
	output logic             done,
	output ctc_pkg::status_t status,
	output logic [12:0]      ptr_out,
	output logic [7:0]       index_out,
	output logic [63:0]      value_out,
	output logic [12:0]      l_nnz,
	output logic [12:0]      u_nnz
);
	import ctc_pkg::*;

	localparam int NW = $clog2(MAX_NNZ + 1);
	localparam int AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int MW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [2:0] {S_IDLE, S_CLR, S_CNT, S_PFX, S_SCT} state_t;
	typedef enum logic [2:0] {K_NONE, K_LPTR, K_UPTR, K_LENT, K_UENT} kind_t;

	state_t          state_q;
	logic [8:0]      dim_q;
	logic [DW-1:0]   d_eff;
	logic            accept;

	logic [NW-1:0]   l_cnt_q, u_cnt_q, l_built_q, u_built_q;
	logic            ptr_ok_q;

	// command path
	status_t         cst;
	kind_t           ckind;
	logic            perm_ok, range_ok, l_full, u_full;
	logic            cmd_v_s1;
	status_t         cst_s1;
	kind_t           ckind_s1;

	// build path
	logic            sel_u_q, skip_q;
	logic [DW-1:0]   j_q, pj_s1;
	logic [NW-1:0]   k_q, acc_q, n_sel;
	logic            v_s1, v_s2, pv_s1, idx_ok_s2;
	logic [MW-1:0]   key_s2;
	logic [63:0]     val_s2;
	logic            issue, key_ok, build_fin;
	coo_t            coo_rd;
	logic [7:0]      key_c, idx_c, map_rd;
	logic [NW-1:0]   fill_rd, fill_cur, fill_wdata;
	logic [MW-1:0]   fill_waddr, fill_raddr;
	logic            fill_we;
	logic            fwd_en_q;
	logic [MW-1:0]   fwd_addr_q;
	logic [NW-1:0]   fwd_val_q;
	logic            ptr_we, csc_we;
	logic [DW-1:0]   ptr_waddr;
	logic [NW-1:0]   ptr_wdata;
	csc_t            csc_wdata;

	// memory ports
	logic            lcoo_we, ucoo_we, map_we;
	coo_t            lcoo_rd, ucoo_rd, coo_wdata;
	logic [7:0]      rmap_rd, cmap_rd;
	logic [NW-1:0]   lptr_rd, uptr_rd;
	csc_t            lcsc_rd, ucsc_rd;

	// output registers
	logic            done_q;
	status_t         status_q;
	logic [12:0]     ptr_q, l_nnz_q, u_nnz_q;
	logic [7:0]      index_q;
	logic [63:0]     value_q;
	logic [12:0]     res_ptr;
	logic [7:0]      res_idx;
	logic [63:0]     res_val;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (dim_q == 9'd0) begin
			d_eff = DW'(1);
		end else if (dim_q > MAX_DIM) begin
			d_eff = DW'(MAX_DIM);
		end else begin
			d_eff = DW'(dim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 9'd256;
		end else if (dim_we) begin
			dim_q <= dim_wdata;
		end
	end

	// ---------------- request decode ----------------
	assign perm_ok  = (pos < d_eff) && (perm_row_entry < d_eff) && (perm_col_entry < d_eff);
	assign range_ok = (row < d_eff) && (col < d_eff);
	assign l_full   = (l_cnt_q == NW'(MAX_NNZ));
	assign u_full   = (u_cnt_q == NW'(MAX_NNZ));

	always_comb begin
		cst   = ST_OK;
		ckind = K_NONE;
		case (func)
			F_PERM: begin
				if (!perm_ok) cst = ST_RANGE;
			end
			F_ADD_L: begin
				if (!range_ok) cst = ST_RANGE;
				else if (l_full) cst = ST_FULL;
			end
			F_ADD_U: begin
				if (!range_ok) cst = ST_RANGE;
				else if (u_full) cst = ST_FULL;
			end
			F_BUILD, F_CLEAR: begin
				cst = ST_OK;
			end
			F_RD_LPTR: begin
				if (pos > d_eff) cst = ST_RANGE;
				else ckind = K_LPTR;
			end
			F_RD_UPTR: begin
				if (pos > d_eff) cst = ST_RANGE;
				else ckind = K_UPTR;
			end
			F_RD_LENT: begin
				if (pos >= l_built_q) cst = ST_RANGE;
				else ckind = K_LENT;
			end
			F_RD_UENT: begin
				if (pos >= u_built_q) cst = ST_RANGE;
				else ckind = K_UENT;
			end
			default: begin
				cst = ST_RANGE;
			end
		endcase
	end

	assign lcoo_we   = accept && (func == F_ADD_L) && (cst == ST_OK);
	assign ucoo_we   = accept && (func == F_ADD_U) && (cst == ST_OK);
	assign map_we    = accept && (func == F_PERM) && (cst == ST_OK);
	assign coo_wdata = '{row: row, col: col, val: value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_cnt_q <= '0;
			u_cnt_q <= '0;
		end else if (accept && (func == F_CLEAR)) begin
			l_cnt_q <= '0;
			u_cnt_q <= '0;
		end else begin
			if (lcoo_we) l_cnt_q <= NW'(l_cnt_q + 1'b1);
			if (ucoo_we) u_cnt_q <= NW'(u_cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else begin
			cmd_v_s1 <= accept && (func != F_BUILD);
		end
	end

	always_ff @(posedge clk) begin
		cst_s1   <= cst;
		ckind_s1 <= ckind;
	end

	// ---------------- build datapath ----------------
	assign n_sel  = sel_u_q ? u_cnt_q : l_cnt_q;
	assign issue  = ((state_q == S_CNT) || (state_q == S_SCT)) && (k_q < n_sel);
	assign coo_rd = sel_u_q ? ucoo_rd : lcoo_rd;
	assign key_c  = sel_u_q ? coo_rd.row : coo_rd.col;
	assign idx_c  = sel_u_q ? coo_rd.col : coo_rd.row;
	assign key_ok = v_s1 && (key_c < d_eff);
	assign map_rd = sel_u_q ? cmap_rd : rmap_rd;

	// last cycle of the U scatter pass
	assign build_fin = (state_q == S_SCT) && sel_u_q && !issue && !v_s1 && !v_s2;

	// take the last write when the read raced it
	assign fill_cur = (fwd_en_q && (fwd_addr_q == key_s2)) ? fwd_val_q : fill_rd;
	assign fill_raddr = (state_q == S_PFX) ? MW'(j_q) : MW'(key_c);

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = MW'(j_q);
		fill_wdata = '0;
		case (state_q)
			S_CLR: begin
				fill_we = 1'b1;
			end
			S_PFX: begin
				fill_we    = pv_s1;
				fill_waddr = MW'(pj_s1);
				fill_wdata = acc_q;
			end
			S_CNT, S_SCT: begin
				fill_we    = v_s2;
				fill_waddr = key_s2;
				fill_wdata = NW'(fill_cur + 1'b1);
			end
			default: begin
				fill_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= fill_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= fill_waddr;
		fwd_val_q  <= fill_wdata;
	end

	assign ptr_we    = (state_q == S_PFX) && (pv_s1 || (j_q == '0));
	assign ptr_waddr = pv_s1 ? DW'(pj_s1 + 1'b1) : '0;
	assign ptr_wdata = pv_s1 ? NW'(acc_q + fill_rd) : '0;

	assign csc_we    = (state_q == S_SCT) && v_s2;
	assign csc_wdata = '{idx: (idx_ok_s2 ? map_rd : 8'd0), val: val_s2};

	always_ff @(posedge clk) begin
		pj_s1     <= j_q;
		key_s2    <= MW'(key_c);
		val_s2    <= coo_rd.val;
		idx_ok_s2 <= (idx_c < MAX_DIM);
	end

	// ---------------- state machine and result registers ----------------
	always_comb begin
		res_ptr = '0;
		res_idx = '0;
		res_val = '0;
		if (cmd_v_s1) begin
			case (ckind_s1)
				K_LPTR: res_ptr = ptr_ok_q ? 13'(lptr_rd) : 13'd0;
				K_UPTR: res_ptr = ptr_ok_q ? 13'(uptr_rd) : 13'd0;
				K_LENT: begin
					res_idx = lcsc_rd.idx;
					res_val = lcsc_rd.val;
				end
				K_UENT: begin
					res_idx = ucsc_rd.idx;
					res_val = ucsc_rd.val;
				end
				default: res_ptr = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_u_q   <= 1'b0;
			skip_q    <= 1'b0;
			j_q       <= '0;
			k_q       <= '0;
			acc_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pv_s1     <= 1'b0;
			l_built_q <= '0;
			u_built_q <= '0;
			ptr_ok_q  <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			ptr_q     <= '0;
			index_q   <= '0;
			value_q   <= '0;
			l_nnz_q   <= '0;
			u_nnz_q   <= '0;
		end else begin
			done_q <= cmd_v_s1 || build_fin;
			if (cmd_v_s1 || build_fin) begin
				status_q <= build_fin ? (skip_q ? ST_RANGE : ST_OK) : cst_s1;
				ptr_q    <= res_ptr;
				index_q  <= res_idx;
				value_q  <= res_val;
				l_nnz_q  <= 13'(l_cnt_q);
				u_nnz_q  <= 13'(u_cnt_q);
			end

			case (state_q)
				S_IDLE: begin
					if (accept && (func == F_CLEAR)) begin
						l_built_q <= '0;
						u_built_q <= '0;
						ptr_ok_q  <= 1'b0;
					end
					if (accept && (func == F_BUILD)) begin
						state_q <= S_CLR;
						sel_u_q <= 1'b0;
						skip_q  <= 1'b0;
						j_q     <= '0;
					end
				end
				S_CLR: begin
					j_q <= DW'(j_q + 1'b1);
					if (j_q == DW'(MAX_DIM - 1)) begin
						state_q <= S_CNT;
						k_q     <= '0;
					end
				end
				S_CNT, S_SCT: begin
					v_s1 <= issue;
					v_s2 <= key_ok;
					if (issue) k_q <= NW'(k_q + 1'b1);
					if (v_s1 && !key_ok) skip_q <= 1'b1;
					if (!issue && !v_s1 && !v_s2) begin
						if (state_q == S_CNT) begin
							state_q <= S_PFX;
							j_q     <= '0;
							acc_q   <= '0;
							pv_s1   <= 1'b0;
						end else if (!sel_u_q) begin
							l_built_q <= acc_q;
							sel_u_q   <= 1'b1;
							state_q   <= S_CLR;
							j_q       <= '0;
						end else begin
							u_built_q <= acc_q;
							ptr_ok_q  <= 1'b1;
							state_q   <= S_IDLE;
						end
					end
				end
				S_PFX: begin
					pv_s1 <= (j_q < DW'(MAX_DIM));
					if (j_q < DW'(MAX_DIM)) j_q <= DW'(j_q + 1'b1);
					if (pv_s1) acc_q <= NW'(acc_q + fill_rd);
					if ((j_q == DW'(MAX_DIM)) && !pv_s1) begin
						state_q <= S_SCT;
						k_q     <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign ptr_out   = ptr_q;
	assign index_out = index_q;
	assign value_out = value_q;
	assign l_nnz     = l_nnz_q;
	assign u_nnz     = u_nnz_q;

	// ---------------- memories ----------------
	ctc_ram #(.WIDTH($bits(coo_t)), .DEPTH(MAX_NNZ)) u_lcoo (
		.clk(clk), .we(lcoo_we), .waddr(AW'(l_cnt_q)), .wdata(coo_wdata),
		.raddr(AW'(k_q)), .rdata(lcoo_rd)
	);

	ctc_ram #(.WIDTH($bits(coo_t)), .DEPTH(MAX_NNZ)) u_ucoo (
		.clk(clk), .we(ucoo_we), .waddr(AW'(u_cnt_q)), .wdata(coo_wdata),
		.raddr(AW'(k_q)), .rdata(ucoo_rd)
	);

	ctc_ram #(.WIDTH(8), .DEPTH(MAX_DIM)) u_rmap (
		.clk(clk), .we(map_we), .waddr(MW'(perm_row_entry)), .wdata(pos[7:0]),
		.raddr(MW'(idx_c)), .rdata(rmap_rd)
	);

	ctc_ram #(.WIDTH(8), .DEPTH(MAX_DIM)) u_cmap (
		.clk(clk), .we(map_we), .waddr(MW'(perm_col_entry)), .wdata(pos[7:0]),
		.raddr(MW'(idx_c)), .rdata(cmap_rd)
	);

	ctc_ram #(.WIDTH(NW), .DEPTH(MAX_DIM)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
		.raddr(fill_raddr), .rdata(fill_rd)
	);

	ctc_ram #(.WIDTH(NW), .DEPTH(MAX_DIM + 1)) u_lptr (
		.clk(clk), .we(ptr_we && !sel_u_q), .waddr(ptr_waddr), .wdata(ptr_wdata),
		.raddr(DW'(pos)), .rdata(lptr_rd)
	);

	ctc_ram #(.WIDTH(NW), .DEPTH(MAX_DIM + 1)) u_uptr (
		.clk(clk), .we(ptr_we && sel_u_q), .waddr(ptr_waddr), .wdata(ptr_wdata),
		.raddr(DW'(pos)), .rdata(uptr_rd)
	);

	ctc_ram #(.WIDTH($bits(csc_t)), .DEPTH(MAX_NNZ)) u_lcsc (
		.clk(clk), .we(csc_we && !sel_u_q), .waddr(AW'(fill_cur)), .wdata(csc_wdata),
		.raddr(AW'(pos)), .rdata(lcsc_rd)
	);

	ctc_ram #(.WIDTH($bits(csc_t)), .DEPTH(MAX_NNZ)) u_ucsc (
		.clk(clk), .we(csc_we && sel_u_q), .waddr(AW'(fill_cur)), .wdata(csc_wdata),
		.raddr(AW'(pos)), .rdata(ucsc_rd)
	);

	// ---------------- checks ----------------
	`CTC_ASSERT_NXT(a_build_holds_busy, accept && (func == F_BUILD), busy)
	`CTC_ASSERT_IMP(a_no_result_clash, cmd_v_s1, (state_q == S_IDLE) || (state_q == S_CLR))
	`CTC_ASSERT_IMP(a_scatter_in_bounds, csc_we, fill_cur < acc_q)
	`CTC_ASSERT_IMP(a_count_bound, 1'b1, (l_cnt_q <= NW'(MAX_NNZ)) && (u_cnt_q <= NW'(MAX_NNZ)))
endmodule
